>>> rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared types and codes for the checked integer alu
// operation and width codes, error codes, transaction structs
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int MaxWidth = 64;
  localparam int DataW    = 64;
  localparam int ShW      = $clog2(DataW);
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_MUL  = 4'd2;
  localparam logic [3:0] ACT_DIV  = 4'd3;
  localparam logic [3:0] ACT_REM  = 4'd4;
  localparam logic [3:0] ACT_AND  = 4'd5;
  localparam logic [3:0] ACT_OR   = 4'd6;
  localparam logic [3:0] ACT_XOR  = 4'd7;
  localparam logic [3:0] ACT_SHL  = 4'd8;
  localparam logic [3:0] ACT_LSHR = 4'd9;
  localparam logic [3:0] ACT_NEG  = 4'd10;
  localparam logic [3:0] ACT_PLUS = 4'd11;
  localparam logic [3:0] ACT_NOT  = 4'd12;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  localparam logic [2:0] WC_8   = 3'd0;
  localparam logic [2:0] WC_16  = 3'd1;
  localparam logic [2:0] WC_32  = 3'd2;
  localparam logic [2:0] WC_64  = 3'd3;
  localparam logic [2:0] WC_PTR = 3'd4;

  localparam logic [1:0] PW_16 = 2'd0;
  localparam logic [1:0] PW_32 = 2'd1;
  localparam logic [1:0] PW_64 = 2'd2;

  typedef struct packed {
    logic [3:0]       action;
    logic [2:0]       width_code;
    logic             is_signed;
    logic [DataW-1:0] lhs;
    logic [DataW-1:0] rhs;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [1:0]       status;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [3:0]       action;
    logic             sgn;
    logic [6:0]       w;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] sbit;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic             an;
    logic             bn;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
  } op_t;

  function automatic logic [6:0] width_bits(input logic [2:0] code,
                                            input logic [1:0] pcode);
    logic [6:0] w;
    unique case (code)
      WC_8:   w = 7'd8;
      WC_16:  w = 7'd16;
      WC_32:  w = 7'd32;
      WC_PTR: w = (pcode == PW_16) ? 7'd16 : (pcode == PW_32) ? 7'd32 : 7'd64;
      default: w = 7'd64;
    endcase
    if (w > 7'(MaxWidth)) w = 7'(MaxWidth);
    return w;
  endfunction

endpackage

>>> rtl/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu: checked integer alu top level
// front classifier, transaction queue, execution back end
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result comes
// out on result_item with done high for one cycle, in order, and cannot be
// held off. Add, sub, logic, shift, neg, plus and not are computed in the back
// end combinationally, so those flow one per cycle while it is idle, through
// the front register, the queue and the result register. Mul registers four
// 32x32 partial products, then forms the sum and overflow compare. Div and rem
// use a restoring divider, one quotient bit a cycle, ending early on divide by
// zero or overflow. A four-entry queue absorbs this; busy rises when it may fill.
module checked_integer_alu (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cia_pkg::in_item_t   item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  output logic                done,
  output cia_pkg::out_item_t  result_item
);

  logic [1:0] pwc;
  logic       f_valid, take, q_ne;
  logic [cia_pkg::QueueAw:0] count;
  cia_pkg::op_t f_op, q_head;

  always_ff @(posedge clk) begin
    if (rst) pwc <= cia_pkg::PW_64;
    else if (cfg_we) pwc <= cfg_wdata;
  end

  // one slot reserved for the transaction in the front register
  assign busy = (count >= (cia_pkg::QueueAw+1)'(cia_pkg::QueueDepth - 1)) ||
                ((count == (cia_pkg::QueueAw+1)'(cia_pkg::QueueDepth - 2)) && f_valid);

  cia_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .item(item), .pwc(pwc),
    .op_valid(f_valid), .op(f_op)
  );

  cia_queue u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .push_data(f_op), .pop(take),
    .not_empty(q_ne), .count(count), .head(q_head)
  );

  cia_back u_back (
    .clk(clk), .rst(rst), .op_valid(q_ne), .op(q_head), .take(take),
    .done(done), .res(result_item)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(f_valid && !take && count == (cia_pkg::QueueAw+1)'(cia_pkg::QueueDepth)))
    else $error("queue overflow");
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst) take |-> q_ne)
    else $error("back end took from empty queue");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result_item.status != cia_pkg::ERR_OK) |-> result_item.result == '0)
    else $error("nonzero result on error");

endmodule

>>> rtl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front: operand classification
// resolves width, masks operands, computes signs and magnitudes
// ----------------------------------------------------------------------------
module cia_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cia_pkg::in_item_t  item,
  input  logic [1:0]         pwc,
  output logic               op_valid,
  output cia_pkg::op_t       op
);

  cia_pkg::op_t op_next;
  logic [6:0] w;
  logic [cia_pkg::DataW-1:0] mask, sbit, a, b;

  always_comb begin
    w    = cia_pkg::width_bits(item.width_code, pwc);
    mask = (w >= 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
    sbit = 64'd1 << (w[5:0] - 6'd1);
    a    = item.lhs & mask;
    b    = item.rhs & mask;
    op_next.action = item.action;
    op_next.sgn    = item.is_signed;
    op_next.w      = w;
    op_next.mask   = mask;
    op_next.sbit   = sbit;
    op_next.a      = a;
    op_next.b      = b;
    op_next.an     = item.is_signed && ((a & sbit) != '0);
    op_next.bn     = item.is_signed && ((b & sbit) != '0);
    op_next.ma     = op_next.an ? ((64'd0 - a) & mask) : a;
    op_next.mb     = op_next.bn ? ((64'd0 - b) & mask) : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= in_valid;
    end
    op <= op_next;
  end

endmodule

>>> rtl/cia_queue.sv
// ----------------------------------------------------------------------------
// cia_queue: small fifo between front and back
// holds classified transactions while the back is busy
// ----------------------------------------------------------------------------
module cia_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cia_pkg::op_t  push_data,
  input  logic          pop,
  output logic          not_empty,
  output logic [cia_pkg::QueueAw:0] count,
  output cia_pkg::op_t  head
);

  cia_pkg::op_t mem [cia_pkg::QueueDepth];
  logic [cia_pkg::QueueAw-1:0] wp, rp;

  assign not_empty = (count != '0);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (cia_pkg::QueueAw+1)'(push) - (cia_pkg::QueueAw+1)'(pop);
    end
    if (push) mem[wp] <= push_data;
  end

endmodule

>>> rtl/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back: execution unit
// combinational simple ops, registered partial-product multiply, bit-serial divide
// ----------------------------------------------------------------------------
module cia_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  input  cia_pkg::op_t       op,
  output logic               take,
  output logic               done,
  output cia_pkg::out_item_t res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state;
  cia_pkg::op_t cur;
  logic [cia_pkg::DataW-1:0] rem_r, quo_r;
  logic [6:0] cnt;
  // multiply partials: 32x32 blocks over magnitudes
  logic [63:0] p_ll, p_lh, p_hl, p_hh;

  logic        is_mul, is_div;
  logic [63:0] r_c;
  logic [1:0]  e_c;
  logic [63:0] sum;
  logic [63:0] dif;

  always_comb begin
    is_mul = (op.action == cia_pkg::ACT_MUL);
    is_div = (op.action == cia_pkg::ACT_DIV) || (op.action == cia_pkg::ACT_REM);
    take   = op_valid && (state == S_IDLE);
    r_c = '0;
    e_c = cia_pkg::ERR_OK;
    sum = op.a + op.b;
    dif = op.a - op.b;
    unique case (op.action)
      cia_pkg::ACT_ADD: begin
        r_c = sum & op.mask;
        if (op.sgn ? (((op.a ^ r_c) & (op.b ^ r_c) & op.sbit) != '0) : (r_c < op.a))
          e_c = cia_pkg::ERR_OVF;
      end
      cia_pkg::ACT_SUB: begin
        r_c = dif & op.mask;
        if (op.sgn ? (((op.a ^ op.b) & (op.a ^ r_c) & op.sbit) != '0) : (op.a < op.b))
          e_c = cia_pkg::ERR_OVF;
      end
      cia_pkg::ACT_AND:  r_c = op.a & op.b;
      cia_pkg::ACT_OR:   r_c = op.a | op.b;
      cia_pkg::ACT_XOR:  r_c = op.a ^ op.b;
      cia_pkg::ACT_SHL:
        r_c = (op.b >= 64'(op.w)) ? '0 : ((op.a << op.b[cia_pkg::ShW-1:0]) & op.mask);
      cia_pkg::ACT_LSHR:
        r_c = (op.b >= 64'(op.w)) ? '0 : (op.a >> op.b[cia_pkg::ShW-1:0]);
      cia_pkg::ACT_NEG: begin
        r_c = (64'd0 - op.a) & op.mask;
        if (op.sgn ? (op.a == op.sbit) : (op.a != '0)) e_c = cia_pkg::ERR_OVF;
      end
      cia_pkg::ACT_PLUS: r_c = op.a;
      cia_pkg::ACT_NOT:  r_c = ~op.a & op.mask;
      default: r_c = '0;
    endcase
  end

  function automatic cia_pkg::out_item_t finish(input logic [63:0] r, input logic [1:0] e,
                                                input cia_pkg::op_t o);
    cia_pkg::out_item_t f;
    f.status = e;
    if (e != cia_pkg::ERR_OK) f.result = '0;
    else if (o.sgn && ((r & o.sbit) != '0)) f.result = r | ~o.mask;
    else f.result = r;
    return f;
  endfunction

  // multiply overflow: full 128-bit product of magnitudes vs limit
  logic [127:0] prod;
  logic [63:0]  lim, prod_r;
  logic         ovf_m;
  // division step, partial remainder can use all 64 bits
  logic [65:0]  trial;
  logic [64:0]  rem_sh;
  logic [63:0]  qv, mv;
  logic [1:0]   e_d;

  always_comb begin
    prod = {p_hh, 64'd0} + {32'd0, p_lh, 32'd0} + {32'd0, p_hl, 32'd0} + {64'd0, p_ll};
    if (cur.sgn) lim = (cur.an != cur.bn) ? cur.sbit : cur.sbit - 64'd1;
    else         lim = cur.mask;
    ovf_m  = (prod > {64'd0, lim});
    prod_r = (cur.an != cur.bn) ? ((64'd0 - prod[63:0]) & cur.mask) : (prod[63:0] & cur.mask);
    rem_sh = {rem_r, quo_r[63]};
    trial  = {1'b0, rem_sh} - {2'b0, cur.mb};
    qv = (cur.an != cur.bn) ? ((64'd0 - quo_r) & cur.mask) : quo_r;
    mv = cur.an ? ((64'd0 - rem_r) & cur.mask) : rem_r;
    e_d = cia_pkg::ERR_OK;
    if (cur.b == '0) e_d = cia_pkg::ERR_DIV0;
    else if (cur.sgn && cur.a == cur.sbit && cur.b == cur.mask) e_d = cia_pkg::ERR_OVF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= ((state == S_IDLE) && op_valid && !is_mul && !is_div) ||
              (state == S_MUL) ||
              ((state == S_DIV) && (cnt == 7'd0 || e_d != cia_pkg::ERR_OK));
      unique case (state)
        S_IDLE: if (op_valid) begin
          if (is_mul)      state <= S_MUL;
          else if (is_div) state <= S_DIV;
        end
        S_MUL: begin
          state <= S_IDLE;
        end
        S_DIV: if (cnt == 7'd0 || e_d != cia_pkg::ERR_OK) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    if (state == S_IDLE && op_valid) begin
      cur   <= op;
      res   <= finish(r_c, e_c, op);
      p_ll  <= op.ma[31:0]  * op.mb[31:0];
      p_lh  <= op.ma[31:0]  * op.mb[63:32];
      p_hl  <= op.ma[63:32] * op.mb[31:0];
      p_hh  <= op.ma[63:32] * op.mb[63:32];
      rem_r <= '0;
      quo_r <= op.ma;
      cnt   <= 7'd64;
    end else if (state == S_MUL) begin
      res <= finish(prod_r, ovf_m ? cia_pkg::ERR_OVF : cia_pkg::ERR_OK, cur);
    end else if (state == S_DIV) begin
      if (e_d != cia_pkg::ERR_OK) begin
        res <= finish('0, e_d, cur);
      end else if (cnt == 7'd0) begin
        res <= finish((cur.action == cia_pkg::ACT_DIV) ? qv : mv, cia_pkg::ERR_OK, cur);
      end else begin
        // restoring divide, one quotient bit a cycle
        if (!trial[65]) begin
          rem_r <= trial[63:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh[63:0];
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
      end
    end
  end

endmodule

>>> tb/checked_integer_alu_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checked_integer_alu_test: self-checking bench for the checked integer alu
// a directed table of corner cases, then random phases under several pointer
// widths and sender gap rates; every transaction is predicted and compared
// ----------------------------------------------------------------------------
module checked_integer_alu_test;

  localparam int WatchdogLimit = 5000;
  localparam int ItemsPerPhase = 244;

  typedef struct {
    cia_pkg::in_item_t  stim;
    bit                 typed;
    cia_pkg::out_item_t want;
  } alu_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cia_pkg::in_item_t item = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic done;
  cia_pkg::out_item_t result_item;

  cia_pkg::out_item_t pending_results[$];
  logic [1:0] ptr_code = cia_pkg::PW_64;
  int mismatches = 0;
  int sent_items = 0;
  int flagged_items = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  checked_integer_alu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result_item(result_item)
  );

  always #6 clk = ~clk;

  function automatic cia_pkg::out_item_t predict_alu(cia_pkg::in_item_t t,
                                                     logic [1:0] pcode);
    int w;
    logic [63:0] mask, sbit, a, b, ma, mb, r, lim, q;
    logic an, bn, sgn;
    logic [1:0] err;
    cia_pkg::out_item_t o;
    case (t.width_code)
      cia_pkg::WC_8:   w = 8;
      cia_pkg::WC_16:  w = 16;
      cia_pkg::WC_32:  w = 32;
      cia_pkg::WC_PTR: w = (pcode == cia_pkg::PW_16) ? 16 :
                           (pcode == cia_pkg::PW_32) ? 32 : 64;
      default: w = 64;
    endcase
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    sbit = 64'd1 << (w - 1);
    sgn = t.is_signed;
    a = t.lhs & mask;
    b = t.rhs & mask;
    an = sgn && ((a & sbit) != 0);
    bn = sgn && ((b & sbit) != 0);
    ma = an ? ((64'd0 - a) & mask) : a;
    mb = bn ? ((64'd0 - b) & mask) : b;
    r = '0;
    err = cia_pkg::ERR_OK;
    case (t.action)
      cia_pkg::ACT_ADD: begin
        r = (a + b) & mask;
        if (sgn ? (((a ^ r) & (b ^ r) & sbit) != 0) : (r < a)) err = cia_pkg::ERR_OVF;
      end
      cia_pkg::ACT_SUB: begin
        r = (a - b) & mask;
        if (sgn ? (((a ^ b) & (a ^ r) & sbit) != 0) : (a < b)) err = cia_pkg::ERR_OVF;
      end
      cia_pkg::ACT_MUL: begin
        r = (a * b) & mask;
        if (sgn) begin
          lim = (an != bn) ? sbit : sbit - 64'd1;
          if (ma != 0 && mb > lim / ma) err = cia_pkg::ERR_OVF;
        end else if (a != 0 && b > mask / a) begin
          err = cia_pkg::ERR_OVF;
        end
      end
      cia_pkg::ACT_DIV, cia_pkg::ACT_REM: begin
        if (b == 0) begin
          err = cia_pkg::ERR_DIV0;
        end else if (sgn && a == sbit && b == mask) begin
          err = cia_pkg::ERR_OVF;
        end else if (t.action == cia_pkg::ACT_DIV) begin
          q = ma / mb;
          r = (an != bn) ? ((64'd0 - q) & mask) : q;
        end else begin
          q = ma % mb;
          r = an ? ((64'd0 - q) & mask) : q;
        end
      end
      cia_pkg::ACT_AND:  r = a & b;
      cia_pkg::ACT_OR:   r = a | b;
      cia_pkg::ACT_XOR:  r = a ^ b;
      cia_pkg::ACT_SHL:  r = (b >= w) ? '0 : ((a << b) & mask);
      cia_pkg::ACT_LSHR: r = (b >= w) ? '0 : (a >> b);
      cia_pkg::ACT_NEG: begin
        r = (64'd0 - a) & mask;
        if (sgn ? (a == sbit) : (a != 0)) err = cia_pkg::ERR_OVF;
      end
      cia_pkg::ACT_PLUS: r = a;
      cia_pkg::ACT_NOT:  r = (~a) & mask;
      default:  r = '0;
    endcase
    if (err != cia_pkg::ERR_OK) r = '0;
    else if (sgn && ((r & sbit) != 0)) r = r | ~mask;
    o.result = r;
    o.status = err;
    return o;
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] edges[12];
    edges = '{64'd0, 64'd1, '1, 64'h80, 64'h7f, 64'h8000, 64'h7fff, 64'h8000_0000,
              64'h7fff_ffff, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'hff};
    case ($urandom_range(5))
      0, 1: return edges[$urandom_range(11)];
      2: return 64'($urandom_range(20));
      3: return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one transaction: idle cycles first, then held until taken
  task automatic send_item(cia_pkg::in_item_t t);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= t;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_alu(t, ptr_code));
    sent_items++;
  endtask

  task automatic write_ptr_code(logic [1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // let the back end drain fully before touching the register
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    ptr_code = v;
    cfg_we <= 1'b0;
  endtask

  // result checker; results cannot be held off
  always @(posedge clk) begin
    cia_pkg::out_item_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: result=%h status=%0d",
               result_item.result, result_item.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.status != cia_pkg::ERR_OK) flagged_items++;
        if (result_item.result !== want.result) begin
          $error("result: expected %h, actual %h", want.result, result_item.result);
          mismatches++;
        end
        if (result_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status,
                 result_item.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    alu_row_t rows[$];
    cia_pkg::in_item_t t;
    cia_pkg::out_item_t got;
    logic [1:0] ptr_seq[8];
    int idle_seq[8];
    ptr_seq = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2};
    idle_seq = '{0, 86, 22, 0, 86, 22, 86, 0};

    // typed rows carry an expectation read off by hand
    rows.push_back('{'{cia_pkg::ACT_ADD, cia_pkg::WC_8, 1'b0, 64'hff, 64'h1}, 1,
                     '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_ADD, cia_pkg::WC_8, 1'b1, 64'h7f, 64'h1}, 1,
                     '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_SUB, cia_pkg::WC_16, 1'b0, 64'h0, 64'h1}, 1,
                     '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_DIV, cia_pkg::WC_32, 1'b0, 64'h5, 64'h0}, 1,
                     '{64'h0, cia_pkg::ERR_DIV0}});
    rows.push_back('{'{cia_pkg::ACT_REM, cia_pkg::WC_64, 1'b1, 64'h5, 64'h0}, 1,
                     '{64'h0, cia_pkg::ERR_DIV0}});
    rows.push_back('{'{cia_pkg::ACT_DIV, cia_pkg::WC_8, 1'b1, 64'h80, 64'hff}, 1,
                     '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_REM, cia_pkg::WC_64, 1'b1, 64'h8000_0000_0000_0000, '1},
                     1, '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_NEG, cia_pkg::WC_16, 1'b0, 64'h3, 64'h0}, 1,
                     '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_NEG, cia_pkg::WC_16, 1'b0, 64'h0, 64'h0}, 1,
                     '{64'h0, cia_pkg::ERR_OK}});
    rows.push_back('{'{cia_pkg::ACT_NEG, cia_pkg::WC_32, 1'b1, 64'h8000_0000, 64'h0}, 1,
                     '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_SHL, cia_pkg::WC_8, 1'b0, 64'hff, 64'd8}, 1,
                     '{64'h0, cia_pkg::ERR_OK}});
    rows.push_back('{'{cia_pkg::ACT_LSHR, cia_pkg::WC_64, 1'b0, '1, 64'd64}, 1,
                     '{64'h0, cia_pkg::ERR_OK}});
    rows.push_back('{'{4'd13, cia_pkg::WC_8, 1'b1, '1, '1}, 1, '{64'h0, cia_pkg::ERR_OK}});
    rows.push_back('{'{4'd15, 3'd7, 1'b0, '1, '1}, 1, '{64'h0, cia_pkg::ERR_OK}});
    rows.push_back('{'{cia_pkg::ACT_PLUS, cia_pkg::WC_8, 1'b1, 64'h80, 64'h0}, 1,
                     '{64'hffff_ffff_ffff_ff80, cia_pkg::ERR_OK}});
    rows.push_back('{'{cia_pkg::ACT_MUL, cia_pkg::WC_64, 1'b0, '1, 64'h2}, 1,
                     '{64'h0, cia_pkg::ERR_OVF}});
    rows.push_back('{'{cia_pkg::ACT_MUL, cia_pkg::WC_PTR, 1'b1, 64'h7fff_ffff_ffff_ffff, '1},
                     0, '{0, 0}});
    rows.push_back('{'{cia_pkg::ACT_AND, 3'd5, 1'b1, '1, 64'h8000_0000_0000_0000}, 0,
                     '{0, 0}});
    rows.push_back('{'{cia_pkg::ACT_OR, 3'd6, 1'b0, 64'h0, '1}, 0, '{0, 0}});
    rows.push_back('{'{cia_pkg::ACT_XOR, cia_pkg::WC_32, 1'b1, '1, 64'h1234_5678_9abc_def0},
                     0, '{0, 0}});
    rows.push_back('{'{cia_pkg::ACT_NOT, cia_pkg::WC_8, 1'b0, 64'h0, 64'h0}, 0, '{0, 0}});
    rows.push_back('{'{cia_pkg::ACT_DIV, cia_pkg::WC_16, 1'b1, 64'h8000, 64'h7}, 0,
                     '{0, 0}});
    rows.push_back('{'{cia_pkg::ACT_REM, cia_pkg::WC_8, 1'b1, 64'hf9, 64'h3}, 0, '{0, 0}});
    rows.push_back('{'{cia_pkg::ACT_SHL, cia_pkg::WC_PTR, 1'b1, 64'h1, 64'd63}, 0,
                     '{0, 0}});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      got = predict_alu(rows[i].stim, ptr_code);
      if (rows[i].typed && got != rows[i].want)
        $error("row %0d: table expectation disagrees with prediction", i);
      send_item(rows[i].stim);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_ptr_code(ptr_seq[ph]);
      idle_pct = idle_seq[ph];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        t.action = ($urandom_range(19) == 0) ? 4'($urandom_range(13, 15))
                                              : 4'($urandom_range(12));
        t.width_code = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(4));
        t.is_signed = 1'($urandom_range(1));
        t.lhs = pick_operand();
        t.rhs = (t.action inside {cia_pkg::ACT_SHL, cia_pkg::ACT_LSHR} && $urandom_range(1))
                ? {$urandom, $urandom} & ~64'hff | 64'($urandom_range(70)) & 64'hff
                : pick_operand();
        // long gap-free bursts in the zero-idle phases
        send_item(t);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("checked %0d transactions over all operations, widths and pointer settings",
             sent_items);
    $display("%0d of them flagged divide by zero or overflow", flagged_items);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
